// File: sv/lstc_pkg.sv
// Shared types and opcode constants for the load/store/transfer core.
package lstc_pkg;

  typedef enum logic [0:0] {
    CMD_EXEC      = 1'b0,
    CMD_READ_DATA = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_AWAIT   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_READ  = 2'd1,
    BUS_WRITE = 2'd2
  } bus_kind_e;

  localparam logic [7:0] OP_TAY     = 8'hA8;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_TSX     = 8'hBA;
  localparam logic [7:0] OP_TYA     = 8'h98;
  localparam logic [7:0] OP_TXA     = 8'h8A;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STA_ZPX = 8'h95;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] read_data;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic        n;
    logic        z;
    logic [15:0] pc;
    logic        load_waiting;
  } arch_t;

  typedef struct packed {
    status_e     status;
    bus_kind_e   bus_kind;
    logic [15:0] bus_address;
    logic [7:0]  bus_write_data;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_ptr;
    logic        negative_flag;
    logic        zero_flag;
    logic [15:0] prog_counter;
  } result_t;

endpackage

// File: sv/cpu_load_store_transfer_core_unit.sv
// Top level: input register, execute unit and result register.
// Executes one 6502-subset instruction (or read-data return) per transfer and takes a new
// transfer every cycle unless a stalled output holds it back; the path runs through the input
// register and then the result register, with execute (opcode decode, 8-bit zero-page index
// add, 16-bit pc increment) between them. A memory load reports status 2 with a bus read; the
// next transfer must be a read-data command, which loads A and sets N and Z.
module cpu_load_store_transfer_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  operand_low_i,
  input  logic [7:0]  operand_high_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  bus_kind_o,
  output logic [15:0] bus_address_o,
  output logic [7:0]  bus_write_data_o,
  output logic [7:0]  accumulator_o,
  output logic [7:0]  index_x_o,
  output logic [7:0]  index_y_o,
  output logic [7:0]  stack_ptr_o,
  output logic        negative_flag_o,
  output logic        zero_flag_o,
  output logic [15:0] prog_counter_o
);
  import lstc_pkg::*;

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q, res;
  logic    out_ready, exec_fire, in_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign exec_fire  = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !exec_fire);
  assign out_valid_d = exec_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: each register holds unless a new transfer or a new result lands.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{command:      cmd_e'(command_i),
                     opcode:       opcode_i,
                     operand_low:  operand_low_i,
                     operand_high: operand_high_i,
                     read_data:    read_data_i};
    end
    if (exec_fire) begin
      out_q <= res;
    end
  end

  lstc_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (exec_fire),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign bus_kind_o       = out_q.bus_kind;
  assign bus_address_o    = out_q.bus_address;
  assign bus_write_data_o = out_q.bus_write_data;
  assign accumulator_o    = out_q.accumulator;
  assign index_x_o        = out_q.index_x;
  assign index_y_o        = out_q.index_y;
  assign stack_ptr_o      = out_q.stack_ptr;
  assign negative_flag_o  = out_q.negative_flag;
  assign zero_flag_o      = out_q.zero_flag;
  assign prog_counter_o   = out_q.prog_counter;

endmodule

// File: sv/lstc_exec.sv
// Architectural registers and combinational instruction execute.
module lstc_exec (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  lstc_pkg::item_t item_i,
  output lstc_pkg::result_t res_o
);
  import lstc_pkg::*;

  arch_t       arch_q, arch_d, nxt;
  logic [1:0]  len;
  logic [7:0]  zpx_addr;
  result_t     res;

  assign zpx_addr = item_i.operand_low + arch_q.x;

  always_comb begin
    nxt            = arch_q;
    len            = 2'd0;
    res.status     = ST_DONE;
    res.bus_kind   = BUS_NONE;
    res.bus_address    = 16'h0000;
    res.bus_write_data = 8'h00;
    if (item_i.command == CMD_READ_DATA) begin
      if (arch_q.load_waiting) begin
        nxt.acc          = item_i.read_data;
        nxt.n            = item_i.read_data[7];
        nxt.z            = (item_i.read_data == 8'h00);
        nxt.load_waiting = 1'b0;
      end else begin
        res.status = ST_IGNORED;
      end
    end else if (arch_q.load_waiting) begin
      res.status = ST_IGNORED;
    end else begin
      unique case (item_i.opcode)
        OP_TAY: begin
          nxt.y = arch_q.acc; nxt.n = arch_q.acc[7]; nxt.z = (arch_q.acc == 8'h00);
        end
        OP_TAX: begin
          nxt.x = arch_q.acc; nxt.n = arch_q.acc[7]; nxt.z = (arch_q.acc == 8'h00);
        end
        OP_TSX: begin
          nxt.x = arch_q.sp; nxt.n = arch_q.sp[7]; nxt.z = (arch_q.sp == 8'h00);
        end
        OP_TYA: begin
          nxt.acc = arch_q.y; nxt.n = arch_q.y[7]; nxt.z = (arch_q.y == 8'h00);
        end
        OP_TXA: begin
          nxt.acc = arch_q.x; nxt.n = arch_q.x[7]; nxt.z = (arch_q.x == 8'h00);
        end
        OP_TXS: begin
          nxt.sp = arch_q.x;
        end
        OP_LDA_IMM: begin
          len = 2'd1;
          nxt.acc = item_i.operand_low;
          nxt.n = item_i.operand_low[7];
          nxt.z = (item_i.operand_low == 8'h00);
        end
        OP_LDX_IMM: begin
          len = 2'd1;
          nxt.x = item_i.operand_low;
          nxt.n = item_i.operand_low[7];
          nxt.z = (item_i.operand_low == 8'h00);
        end
        OP_LDY_IMM: begin
          len = 2'd1;
          nxt.y = item_i.operand_low;
          nxt.n = item_i.operand_low[7];
          nxt.z = (item_i.operand_low == 8'h00);
        end
        OP_LDA_ZP: begin
          len = 2'd1;
          res.bus_kind    = BUS_READ;
          res.bus_address = {8'h00, item_i.operand_low};
        end
        OP_LDA_ZPX: begin
          len = 2'd1;
          res.bus_kind    = BUS_READ;
          res.bus_address = {8'h00, zpx_addr};
        end
        OP_LDA_ABS: begin
          len = 2'd2;
          res.bus_kind    = BUS_READ;
          res.bus_address = {item_i.operand_high, item_i.operand_low};
        end
        OP_STA_ZP: begin
          len = 2'd1;
          res.bus_kind       = BUS_WRITE;
          res.bus_address    = {8'h00, item_i.operand_low};
          res.bus_write_data = arch_q.acc;
        end
        OP_STA_ZPX: begin
          len = 2'd1;
          res.bus_kind       = BUS_WRITE;
          res.bus_address    = {8'h00, zpx_addr};
          res.bus_write_data = arch_q.acc;
        end
        default: begin
          res.status = ST_ILLEGAL;
        end
      endcase
      if (res.bus_kind == BUS_READ) begin
        res.status       = ST_AWAIT;
        nxt.load_waiting = 1'b1;
      end
      nxt.pc = arch_q.pc + 16'({14'd0, len}) + 16'd1;
    end
    res.accumulator   = nxt.acc;
    res.index_x       = nxt.x;
    res.index_y       = nxt.y;
    res.stack_ptr     = nxt.sp;
    res.negative_flag = nxt.n;
    res.zero_flag     = nxt.z;
    res.prog_counter  = nxt.pc;
  end

  assign arch_d = fire_i ? nxt : arch_q;
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q <= '0;
    end else begin
      arch_q <= arch_d;
    end
  end

`ifndef ASSERT_OFF
  a_await_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.status == ST_AWAIT |=> arch_q.load_waiting)
    else $error("load issued but no pending mark");

  a_read_iff_await: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.bus_kind == BUS_READ) == (res.status == ST_AWAIT))
    else $error("bus read and await status disagree");

  a_ignored_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.status == ST_IGNORED |=> $stable(arch_q))
    else $error("ignored transfer changed state");

  a_illegal_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.status == ST_ILLEGAL |=> arch_q.pc == $past(arch_q.pc) + 16'd1)
    else $error("illegal opcode did not advance pc by one");
`endif

endmodule
